// ===== src/rgbpwm_pkg.sv =====
// Shared types and constants of the RGB LED PWM duty encoder.
`default_nettype none

package rgbpwm_pkg;

	localparam int BITS_PER_PIXEL = 24;
	localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL + 1);
	localparam int COLOR_W        = 8;
	localparam int GAP_W          = 6;
	localparam int DUTY_W         = 16;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS  = 8'd0,
		REG_HIGH_DUTY   = 8'd1,
		REG_LOW_DUTY    = 8'd2,
		REG_RESET_SLOTS = 8'd3
	} reg_idx_t;

	// One pixel handed from the front pipeline to the serializer.
	typedef struct packed {
		logic                      valid;
		logic [BITS_PER_PIXEL-1:0] word;
		logic [GAP_W-1:0]          gap;
	} load_t;

	typedef struct packed {
		logic [DUTY_W-1:0] high;
		logic [DUTY_W-1:0] low;
	} duty_cfg_t;

endpackage

`default_nettype wire

// ===== src/rgb_led_pwm_duty_encoder.sv =====
// Top level of the GRB LED strip PWM duty encoder.
`default_nettype none

// Takes one pixel per request (green, red, blue bytes and a last-pixel mark)
// and emits one timer duty value per color bit, GRB order, MSB first: the
// high_duty register for a one and low_duty for a zero, after each byte is
// scaled as (byte * brightness) >> 8. A pixel marked last is followed by
// reset_slots zero-duty latch-gap slots (capped at MAX_RESET_SLOTS, none when
// the register is 0). The final slot of each pixel carries run_end.
// Rate: the serializer at the back hands out one slot per cycle while
// out_ready allows, so a pixel occupies it for its 24 bit slots, plus its
// gap slots if it is a last pixel; the next pixel's first slot follows its
// predecessor's final slot directly. Three pipeline stages in front (input
// register, brightness multiply, packing) keep up to three more pixels
// queued, so in_ready stays high until that queue is full.
// Registers are written through the cfg port (index 0 brightness, 1
// high_duty, 2 low_duty, 3 reset_slots; other indexes are ignored); cfg_ready
// is always high, and writes belong only to idle periods.
module rgb_led_pwm_duty_encoder #(
	parameter int MAX_RESET_SLOTS = 40
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rgbpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rgbpwm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rgbpwm_pkg::COLOR_W-1:0] green,
	input  wire logic [rgbpwm_pkg::COLOR_W-1:0] red,
	input  wire logic [rgbpwm_pkg::COLOR_W-1:0] blue,
	input  wire logic                           last_pixel,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [rgbpwm_pkg::DUTY_W-1:0]       duty,
	output logic                                in_reset_gap,
	output logic                                run_end
);
	import rgbpwm_pkg::*;

	// Configuration registers
	logic [COLOR_W-1:0] brightness_q;
	logic [DUTY_W-1:0]  high_duty_q;
	logic [DUTY_W-1:0]  low_duty_q;
	logic [GAP_W-1:0]   reset_slots_q;

	// Stage 1: captured pixel
	logic               valid_s1;
	logic [COLOR_W-1:0] green_s1;
	logic [COLOR_W-1:0] red_s1;
	logic [COLOR_W-1:0] blue_s1;
	logic               last_s1;

	// Stage 2: scaled bytes
	logic               valid_s2;
	logic [COLOR_W-1:0] green_s2;
	logic [COLOR_W-1:0] red_s2;
	logic [COLOR_W-1:0] blue_s2;
	logic               last_s2;

	// Stage 3: packed word and gap length for the serializer
	logic                      valid_s3;
	logic [BITS_PER_PIXEL-1:0] word_s3;
	logic [GAP_W-1:0]          gap_s3;
	load_t                     load_s3;

	logic en_s1;
	logic en_s2;
	logic en_s3;
	logic ser_ready;

	logic [2*COLOR_W-1:0] prod_g;
	logic [2*COLOR_W-1:0] prod_r;
	logic [2*COLOR_W-1:0] prod_b;
	logic [GAP_W-1:0]     gap_sat;
	duty_cfg_t            duty_cfg;

	// Configuration write port: always ready, unknown indexes drop the write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= COLOR_W'(255);
			high_duty_q   <= DUTY_W'(68);
			low_duty_q    <= DUTY_W'(34);
			reset_slots_q <= GAP_W'(40);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BRIGHTNESS:  brightness_q  <= cfg_data[COLOR_W-1:0];
				REG_HIGH_DUTY:   high_duty_q   <= cfg_data[DUTY_W-1:0];
				REG_LOW_DUTY:    low_duty_q    <= cfg_data[DUTY_W-1:0];
				REG_RESET_SLOTS: reset_slots_q <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Stall chain: a stage advances when it is empty or the next one moves.
	assign en_s3    = !valid_s3 || ser_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	// Scale each byte; keep the upper half of the product.
	assign prod_g = (2*COLOR_W)'(green_s1) * (2*COLOR_W)'(brightness_q);
	assign prod_r = (2*COLOR_W)'(red_s1)   * (2*COLOR_W)'(brightness_q);
	assign prod_b = (2*COLOR_W)'(blue_s1)  * (2*COLOR_W)'(brightness_q);

	// Cap the latch gap; only a last pixel gets one.
	assign gap_sat = (reset_slots_q > GAP_W'(MAX_RESET_SLOTS)) ? GAP_W'(MAX_RESET_SLOTS)
	                                                          : reset_slots_q;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			green_s1 <= green;
			red_s1   <= red;
			blue_s1  <= blue;
			last_s1  <= last_pixel;
		end
		if (en_s2) begin
			green_s2 <= prod_g[2*COLOR_W-1:COLOR_W];
			red_s2   <= prod_r[2*COLOR_W-1:COLOR_W];
			blue_s2  <= prod_b[2*COLOR_W-1:COLOR_W];
			last_s2  <= last_s1;
		end
		if (en_s3) begin
			word_s3 <= {green_s2, red_s2, blue_s2};
			gap_s3  <= last_s2 ? gap_sat : '0;
		end
	end

	// Member order: valid, word, gap.
	assign load_s3  = {valid_s3, word_s3, gap_s3};
	// Member order: high, low.
	assign duty_cfg = {high_duty_q, low_duty_q};

	rgbpwm_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load_s3),
		.load_ready   (ser_ready),
		.duty_cfg     (duty_cfg),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duty         (duty),
		.in_reset_gap (in_reset_gap),
		.run_end      (run_end)
	);

`ifndef NO_ASSERTIONS
	// Latch-gap slots always carry zero duty.
	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_reset_gap |-> duty == '0)
		else $error("latch-gap slot with nonzero duty");

	// Once the gap has started, its slots follow without a hole.
	a_gap_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && in_reset_gap && !run_end |=> out_valid && in_reset_gap)
		else $error("latch gap interrupted");

	// Requests are refused only when every front stage holds a pixel.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && valid_s3)
		else $error("in_ready low with a free pipeline stage");
`endif

endmodule

`default_nettype wire

// ===== src/rgbpwm_serializer.sv =====
// Bit serializer: turns one packed GRB word plus gap count into duty slots.
`default_nettype none

module rgbpwm_serializer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rgbpwm_pkg::load_t          load,
	output logic                            load_ready,
	input  wire rgbpwm_pkg::duty_cfg_t      duty_cfg,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [rgbpwm_pkg::DUTY_W-1:0]   duty,
	output logic                            in_reset_gap,
	output logic                            run_end
);
	import rgbpwm_pkg::*;

	logic                      busy_q;
	logic                      out_valid_q;
	logic [BITS_PER_PIXEL-1:0] word_q;
	logic [BIT_CNT_W-1:0]      bit_cnt_q;
	logic [GAP_W-1:0]          gap_cnt_q;
	logic [DUTY_W-1:0]         duty_q;
	logic                      gap_q;
	logic                      end_q;

	logic emit_ok;
	logic emit;
	logic in_bits;
	logic item_end;
	logic take;

	assign emit_ok    = !out_valid_q || out_ready;
	assign emit       = busy_q && emit_ok;
	assign in_bits    = (bit_cnt_q != '0);
	assign item_end   = in_bits ? ((bit_cnt_q == BIT_CNT_W'(1)) && (gap_cnt_q == '0))
	                            : (gap_cnt_q == GAP_W'(1));
	// Accept the next word as the current one hands out its final slot.
	assign load_ready = !busy_q || (emit && item_end);
	assign take       = load.valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			gap_cnt_q   <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= BIT_CNT_W'(BITS_PER_PIXEL);
				gap_cnt_q <= load.gap;
			end else if (emit) begin
				if (in_bits) begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
				end else begin
					gap_cnt_q <= gap_cnt_q - GAP_W'(1);
				end
				if (item_end) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			duty_q <= in_bits ? (word_q[BITS_PER_PIXEL-1] ? duty_cfg.high : duty_cfg.low)
			                  : '0;
			gap_q  <= !in_bits;
			end_q  <= item_end;
		end
		if (take) begin
			word_q <= load.word;
		end else if (emit && in_bits) begin
			word_q <= {word_q[BITS_PER_PIXEL-2:0], 1'b0};
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign in_reset_gap = gap_q;
	assign run_end      = end_q;

endmodule

`default_nettype wire

// ===== dv/tb_rgb_led_pwm_duty_encoder.sv =====
// Self-checking testbench for the GRB LED strip PWM duty encoder.
`timescale 1ns / 100ps

module tb_rgb_led_pwm_duty_encoder;

	import rgbpwm_pkg::*;

	localparam int GAP_MAX        = 40;    // latch gap cap of the instance
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
	localparam int TAIL_CYCLES    = 16;    // settle time after the last slot

	// Indexes with no register behind them; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = 8'hFF;

	// One expected PWM slot.
	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              in_gap;
		logic              run_end;
	} duty_slot_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [COLOR_W-1:0]    green        = '0;
	logic [COLOR_W-1:0]    red          = '0;
	logic [COLOR_W-1:0]    blue         = '0;
	logic                  last_pixel   = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [DUTY_W-1:0]     duty;
	logic                  in_reset_gap;
	logic                  run_end;

	// Shadow copy of the register file, updated at each accepted write.
	logic [COLOR_W-1:0] bright_r;
	logic [DUTY_W-1:0]  high_duty_r;
	logic [DUTY_W-1:0]  low_duty_r;
	logic [GAP_W-1:0]   gap_slots_r;

	duty_slot_t slot_q[$];  // slots still owed by the DUT, oldest first

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors        = 0;
	int pixels_sent   = 0;
	int slots_checked = 0;
	int gap_slots_seen = 0;
	int cfg_writes    = 0;
	int quiet_cycles  = 0;

	rgb_led_pwm_duty_encoder #(
		.MAX_RESET_SLOTS(GAP_MAX)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.green       (green),
		.red         (red),
		.blue        (blue),
		.last_pixel  (last_pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.duty        (duty),
		.in_reset_gap(in_reset_gap),
		.run_end     (run_end)
	);

	// 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Apply brightness: keep the upper byte of the 16-bit product.
	function automatic logic [COLOR_W-1:0] dim_byte(input logic [COLOR_W-1:0] c);
		logic [2*COLOR_W-1:0] prod;
		prod = (2*COLOR_W)'(c) * (2*COLOR_W)'(bright_r);
		return prod[2*COLOR_W-1:COLOR_W];
	endfunction

	// Queue the slots of one pixel: 24 color bits G-R-B, MSB first, then the
	// latch gap when the pixel closes a frame. Mark the final slot run_end.
	function automatic void encode_pixel(input logic [COLOR_W-1:0] g, r, b,
			input logic end_frame);
		logic [BITS_PER_PIXEL-1:0] word;
		duty_slot_t s;
		int gap;
		int total;
		word  = {dim_byte(g), dim_byte(r), dim_byte(b)};
		gap   = 0;
		if (end_frame) begin
			// clamp an oversized gap register to the cap
			gap = (gap_slots_r > GAP_MAX) ? GAP_MAX : int'(gap_slots_r);
		end
		total = BITS_PER_PIXEL + gap;
		for (int k = 0; k < total; k++) begin
			if (k < BITS_PER_PIXEL) begin
				s.duty   = word[BITS_PER_PIXEL-1-k] ? high_duty_r : low_duty_r;
				s.in_gap = 1'b0;
			end else begin
				s.duty   = '0;
				s.in_gap = 1'b1;
			end
			s.run_end = (k == total - 1);
			slot_q.push_back(s);
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking: compare each accepted slot with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		duty_slot_t want;
		if (arst_n && out_valid && out_ready) begin
			if (slot_q.size() == 0) begin
				$error("slot with nothing owed: duty=%0d in_reset_gap=%0b run_end=%0b",
					duty, in_reset_gap, run_end);
				errors++;
			end else begin
				want = slot_q.pop_front();
				slots_checked++;
				if (want.in_gap)
					gap_slots_seen++;
				if (duty !== want.duty) begin
					$error("duty: expected %0d, got %0d", want.duty, duty);
					errors++;
				end
				if (in_reset_gap !== want.in_gap) begin
					$error("in_reset_gap: expected %0b, got %0b", want.in_gap, in_reset_gap);
					errors++;
				end
				if (run_end !== want.run_end) begin
					$error("run_end: expected %0b, got %0b", want.run_end, run_end);
					errors++;
				end
			end
		end
	end

	// Receiver: drop ready in recv_idle_pct cycles of a hundred.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Watchdog: end the run if no handshake moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d slots still owed",
				quiet_cycles, slot_q.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------

	// Write one register. Leave cfg_valid high so back-to-back writes do not
	// toggle it within one step; cfg_release drops it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BRIGHTNESS:  bright_r    = data[COLOR_W-1:0];
			REG_HIGH_DUTY:   high_duty_r = data[DUTY_W-1:0];
			REG_LOW_DUTY:    low_duty_r  = data[DUTY_W-1:0];
			REG_RESET_SLOTS: gap_slots_r = data[GAP_W-1:0];
			default: ;  // no register there: write is dropped
		endcase
		cfg_writes++;
	endtask

	task automatic cfg_release();
		cfg_valid <= 1'b0;
	endtask

	// Present one pixel request and queue its slots once accepted. Valid stays
	// high after acceptance; the next call either lowers it for an idle spell
	// or reuses it for the next pixel.
	task automatic send_pixel(input logic [COLOR_W-1:0] g, r, b, input logic end_frame);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		green      <= g;
		red        <= r;
		blue       <= b;
		last_pixel <= end_frame;
		do @(posedge clk); while (!in_ready);
		encode_pixel(g, r, b, end_frame);
		pixels_sent++;
	endtask

	// Hold off requests until every owed slot has come out.
	task automatic drain_slots();
		in_valid <= 1'b0;
		while (slot_q.size() != 0)
			@(posedge clk);
	endtask

	// Pick a fresh register setting, extremes included; upper data bits are
	// random to prove they are masked.
	task automatic randomize_regs();
		logic [COLOR_W-1:0] b;
		logic [GAP_W-1:0]   s;
		logic [DUTY_W-1:0]  hi;
		logic [DUTY_W-1:0]  lo;
		case ($urandom_range(0, 3))
			0:       b = '0;
			1:       b = '1;
			default: b = COLOR_W'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0:       s = '0;
			1:       s = GAP_W'(GAP_MAX);
			2:       s = GAP_W'(GAP_MAX + 1);
			3:       s = '1;
			default: s = GAP_W'($urandom_range(1, 12));
		endcase
		hi = ($urandom_range(0, 4) == 0) ? '1 : DUTY_W'($urandom);
		lo = ($urandom_range(0, 4) == 0) ? '0 : DUTY_W'($urandom);
		write_reg(REG_BRIGHTNESS, {8'($urandom), b});
		write_reg(REG_HIGH_DUTY, hi);
		write_reg(REG_LOW_DUTY, lo);
		write_reg(REG_RESET_SLOTS, {10'($urandom), s});
		cfg_release();
	endtask

	// Random color byte, now and then pinned to an extreme.
	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: full brightness caps at 254, 68/34 duties, 40-slot gap.
	task automatic test_reset_values();
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hA5, 8'h5A, 8'h81, 1'b1);
	endtask

	// Brightness and duty extremes.
	task automatic test_scale_extremes();
		drain_slots();
		write_reg(REG_BRIGHTNESS, 16'h0000);
		write_reg(REG_HIGH_DUTY, 16'hFFFF);
		write_reg(REG_LOW_DUTY, 16'h0000);
		cfg_release();
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);   // everything scales to zero
		drain_slots();
		write_reg(REG_BRIGHTNESS, 16'h0001);
		cfg_release();
		send_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
		drain_slots();
		write_reg(REG_BRIGHTNESS, 16'h0080);
		cfg_release();
		send_pixel(8'hFF, 8'h80, 8'h01, 1'b1);
		drain_slots();
		write_reg(REG_BRIGHTNESS, 16'h00FF);
		write_reg(REG_HIGH_DUTY, 16'h0000);
		write_reg(REG_LOW_DUTY, 16'hFFFF);
		cfg_release();
		send_pixel(8'hFF, 8'hFE, 8'h7F, 1'b0);
	endtask

	// Latch gap lengths: none, one, the cap, just over it, register maximum.
	task automatic test_gap_lengths();
		logic [GAP_W-1:0] lens [5];
		lens = '{6'd0, 6'd1, 6'(GAP_MAX), 6'(GAP_MAX + 1), 6'h3F};
		foreach (lens[i]) begin
			drain_slots();
			write_reg(REG_RESET_SLOTS, {10'd0, lens[i]});
			cfg_release();
			send_pixel(pick_color(), pick_color(), pick_color(), 1'b1);
		end
		// a pixel not closing a frame ignores the gap register
		send_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
	endtask

	// Dead indexes change nothing; bits above a register's width are masked.
	task automatic test_register_writes();
		drain_slots();
		write_reg(REG_UNUSED, 16'h0000);
		write_reg(REG_IDX_TOP, 16'hFFFF);
		write_reg(REG_BRIGHTNESS, 16'hFF40);
		write_reg(REG_RESET_SLOTS, 16'hFFC3);
		write_reg(REG_HIGH_DUTY, 16'h1234);
		write_reg(REG_LOW_DUTY, 16'h00FF);
		cfg_release();
		send_pixel(8'hC3, 8'h3C, 8'h99, 1'b0);
		send_pixel(8'h7E, 8'h81, 8'hFF, 1'b1);
	endtask

	// Random frames of one to six pixels under the given idle rates. Reprogram
	// now and then at a frame boundary, and sometimes drain mid-frame.
	task automatic test_random_frames(input int pixels, input int send_pct,
			input int recv_pct);
		int left;
		int frame_len;
		logic end_frame;
		drain_slots();
		randomize_regs();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		left = pixels;
		while (left > 0) begin
			frame_len = $urandom_range(1, 6);
			for (int k = 0; k < frame_len && left > 0; k++) begin
				end_frame = (k == frame_len - 1);
				if ($urandom_range(0, 9) == 0)
					end_frame = ~end_frame;   // broken framing now and then
				send_pixel(pick_color(), pick_color(), pick_color(), end_frame);
				left--;
				if ($urandom_range(0, 24) == 0)
					drain_slots();
			end
			if (left > 0 && $urandom_range(0, 5) == 0) begin
				drain_slots();
				randomize_regs();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		bright_r    = 8'd255;
		high_duty_r = 16'd68;
		low_duty_r  = 16'd34;
		gap_slots_r = 6'd40;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_scale_extremes();
		test_gap_lengths();
		test_register_writes();
		test_random_frames(45, 21, 85);
		test_random_frames(45, 85, 21);
		test_random_frames(45, 0, 0);

		drain_slots();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d pixels, %0d duty slots (%0d latch gap), %0d register writes",
			pixels_sent, slots_checked, gap_slots_seen, cfg_writes);
		$display("brightness/duty extremes, gap lengths 0..63, dead indexes, idle mixes");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
